@@ hdl/hcbp_pkg.sv @@
// Package for the Huffman code bit packer: widths, operation and register codes,
// and the result beat and queue push types. No dependencies.

package hcbp_pkg;

    localparam int WORD_BITS   = 8;
    localparam int SYM_BITS    = 8;
    localparam int LEN_BITS    = 4;
    localparam int COUNT_BITS  = 32;
    localparam int TABLE_DEPTH = 256;
    localparam int ENTRY_BITS  = WORD_BITS + LEN_BITS;
    localparam int CFG_ADDR_BITS = 3;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    // register word index
    localparam logic CFG_IDX_END_SYMBOL = 1'b0;

    // one output beat
    typedef struct packed {
        logic [WORD_BITS-1:0]  out_byte;
        logic                  last;
        logic [COUNT_BITS-1:0] byte_count;
    } result_t;

    // beats pushed into the output queue in one cycle (0, 1 or 2)
    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

@@ hdl/hcbp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module hcbp_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, hold when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/hcbp_out_fifo.sv @@
// Output beat queue of the Huffman code bit packer: takes up to two beats a
// cycle, hands one beat a cycle to a ready output channel. Uses hcbp_pkg.

module hcbp_out_fifo
    import hcbp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    space_ok,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_beat
);

    result_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_plus1;
    logic                     pop;

    assign out_valid = (count_reg != '0);
    assign out_beat  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a worst-case push of two beats
    assign space_ok  = (count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_BITS'(1);

    // advance pointers and occupancy
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(pop);
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(push.num);
        count_next  = count_reg + FIFO_CNT_BITS'(push.num) - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store pushed beats
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

@@ hdl/huffman_code_bit_packer.sv @@
// Top level of the Huffman code bit packer: input handling, code table, packing
// logic and register port. Uses hcbp_pkg, hcbp_ram and hcbp_out_fifo.
//
// The packer takes one item per cycle. An item is accepted and its table entry is
// read from the 256-entry code RAM in that cycle; when the queue has room the code
// is merged into the partial byte and up to two output beats (a full byte and,
// for the end symbol, the final byte marked last) go into a four-beat output
// queue. A table write takes effect at once, so an encode may follow it on the
// very next cycle. Input is held off only while the queue has fewer than two
// free slots, so sustained rate is one item per cycle as long as the output side
// takes one beat per cycle; a stream's end symbol adds one extra beat. The code
// table has no reset: encode only symbols whose entries have been written.

module huffman_code_bit_packer
    import hcbp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // input channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic [SYM_BITS-1:0]      symbol,
    input  logic [WORD_BITS-1:0]     code_word,
    input  logic [LEN_BITS-1:0]      code_length,
    // output channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [WORD_BITS-1:0]     out_byte,
    output logic                     last,
    output logic [COUNT_BITS-1:0]    byte_count,
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [SYM_BITS-1:0]   end_symbol_reg;
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_end_reg;
    logic [WORD_BITS-1:0]  partial_reg, partial_next;
    logic [LEN_BITS-1:0]   filled_reg, filled_next;
    logic [COUNT_BITS-1:0] emitted_reg, emitted_next;

    logic                  accept;
    logic                  fire;
    logic                  space_ok;
    logic                  cfg_write;
    logic                  cfg_is_end;
    logic [ENTRY_BITS-1:0] rd_entry;
    logic [LEN_BITS-1:0]   len_raw, len_eff;
    logic [WORD_BITS-1:0]  code_raw, code_mask, code;
    logic [WORD_BITS-1:0]  shift_hi, shift_lo, merged;
    logic [LEN_BITS:0]     bit_sum;
    logic                  overflow;
    logic [COUNT_BITS-1:0] count_a, count_b, count_mid;
    push_t                 push;
    result_t               out_beat;
    result_t               full_beat, end_beat;

    // register port
    assign pready     = 1'b1;
    assign cfg_is_end = (paddr[CFG_ADDR_BITS-1] == CFG_IDX_END_SYMBOL);
    assign cfg_write  = psel && penable && pwrite && cfg_is_end;
    assign prdata     = cfg_is_end ? {{(32-SYM_BITS){1'b0}}, end_symbol_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_symbol_reg <= '0;
        end
        else if (cfg_write)
        begin
            end_symbol_reg <= pwdata[SYM_BITS-1:0];
        end
    end

    // input handshake: take a beat whenever the packing stage is free or moving
    assign fire     = s1_valid_reg && space_ok;
    assign in_ready = !s1_valid_reg || space_ok;
    assign accept   = in_valid && in_ready;

    // code table: {codeword, length}
    hcbp_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (accept && (operation == OP_WRITE)),
        .waddr(symbol),
        .wdata({code_word, code_length}),
        .re   (accept && (operation == OP_ENCODE)),
        .raddr(symbol),
        .rdata(rd_entry)
    );

    // packing stage control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = (operation == OP_ENCODE);
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // end-of-stream flag rides along with the read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_end_reg <= (symbol == end_symbol_reg);
        end
    end

    // clamp the length and drop codeword bits below it
    assign len_raw   = rd_entry[LEN_BITS-1:0];
    assign code_raw  = rd_entry[ENTRY_BITS-1:LEN_BITS];
    assign len_eff   = (len_raw > LEN_BITS'(WORD_BITS)) ? LEN_BITS'(WORD_BITS) : len_raw;
    assign code_mask = WORD_BITS'({{WORD_BITS{1'b1}}, {WORD_BITS{1'b0}}} >> len_eff);
    assign code      = code_raw & code_mask;

    // align the code at the fill offset; low part carries into the next byte
    assign shift_hi = code >> filled_reg;
    assign shift_lo = WORD_BITS'({code, {WORD_BITS{1'b0}}} >> filled_reg);
    assign merged   = partial_reg | shift_hi;
    assign bit_sum  = (LEN_BITS+1)'(filled_reg) + (LEN_BITS+1)'(len_eff);
    assign overflow = (bit_sum > (LEN_BITS+1)'(WORD_BITS));

    // saturating byte counts for the two possible beats
    assign count_a   = (emitted_reg == COUNT_MAX) ? emitted_reg : emitted_reg + 1'b1;
    assign count_mid = overflow ? count_a : emitted_reg;
    assign count_b   = (count_mid == COUNT_MAX) ? count_mid : count_mid + 1'b1;

    // next packer state and the beats to push
    always_comb
    begin
        if (overflow)
        begin
            partial_next = shift_lo;
            filled_next  = LEN_BITS'(bit_sum - (LEN_BITS+1)'(WORD_BITS));
        end
        else
        begin
            partial_next = merged;
            filled_next  = bit_sum[LEN_BITS-1:0];
        end
        emitted_next = count_mid;

        full_beat.out_byte   = merged;
        full_beat.last       = 1'b0;
        full_beat.byte_count = count_a;

        end_beat.out_byte    = partial_next;
        end_beat.last        = 1'b1;
        end_beat.byte_count  = count_b;

        if (s1_end_reg)
        begin
            partial_next = '0;
            filled_next  = '0;
            emitted_next = '0;
        end

        push.num    = 2'd0;
        push.first  = overflow ? full_beat : end_beat;
        push.second = end_beat;
        if (fire)
        begin
            push.num = 2'(overflow) + 2'(s1_end_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            filled_reg  <= '0;
            emitted_reg <= '0;
        end
        else if (fire)
        begin
            partial_reg <= partial_next;
            filled_reg  <= filled_next;
            emitted_reg <= emitted_next;
        end
    end

    // output queue
    hcbp_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_beat (out_beat)
    );

    assign out_byte   = out_beat.out_byte;
    assign last       = out_beat.last;
    assign byte_count = out_beat.byte_count;

endmodule

@@ bench/tb.sv @@
// Testbench for huffman_code_bit_packer: table writes and symbol streams are checked
// beat by beat against a local model of the bit packer. Depends on hcbp_pkg and the RTL.
`timescale 1ns / 1ps

module tb
    import hcbp_pkg::*;
();

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 140;

    typedef struct packed {
        logic                 op;
        logic [SYM_BITS-1:0]  sym;
        logic [WORD_BITS-1:0] code;
        logic [LEN_BITS-1:0]  len;
    } packer_item_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     operation = OP_WRITE;
    logic [SYM_BITS-1:0]      symbol = '0;
    logic [WORD_BITS-1:0]     code_word = '0;
    logic [LEN_BITS-1:0]      code_length = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [WORD_BITS-1:0]     out_byte;
    logic                     last;
    logic [COUNT_BITS-1:0]    byte_count;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    // stimulus and expectations
    packer_item_t pending_items[$];
    result_t      expected_bytes[$];
    int           mismatches = 0;

    // packer model state
    logic [WORD_BITS-1:0]  tab_code [TABLE_DEPTH];
    logic [LEN_BITS-1:0]   tab_len  [TABLE_DEPTH];
    logic [WORD_BITS-1:0]  held_byte = '0;
    int unsigned           held_bits = 0;
    logic [COUNT_BITS-1:0] stream_count = '0;
    logic [SYM_BITS-1:0]   end_sym_cfg = '0;

    // generator bookkeeping: which table entries are safe to encode
    bit                  gen_written [TABLE_DEPTH];
    logic [SYM_BITS-1:0] known_syms[$];

    // handshake and idling control
    logic in_fire = 1'b0;
    logic idle_bursts = 1'b1;
    logic rx_hold_req = 1'b0;
    logic rx_hold_done = 1'b0;
    int   rx_hold_left = 0;
    int   rx_gap = 0;
    int   tx_gap = 0;
    int   quiet_cycles = 0;

    huffman_code_bit_packer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last        (last),
        .byte_count  (byte_count),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // emit one packed byte, counting it in the stream
    task automatic emit_byte(input logic [WORD_BITS-1:0] value, input logic is_last);
        result_t beat;
        if (stream_count != COUNT_MAX)
            stream_count++;
        beat.out_byte   = value;
        beat.last       = is_last;
        beat.byte_count = stream_count;
        expected_bytes.push_back(beat);
    endtask

    // advance the packer model by one accepted item
    task automatic pack_item(input packer_item_t it);
        int unsigned          n;
        logic [WORD_BITS-1:0] cw;
        if (it.op == OP_WRITE)
        begin
            tab_code[it.sym] = it.code;
            tab_len[it.sym]  = it.len;
            return;
        end
        n  = (tab_len[it.sym] > WORD_BITS) ? WORD_BITS : tab_len[it.sym];
        // drop codeword bits below its length
        cw = tab_code[it.sym] & ~(8'hFF >> n);
        if (held_bits + n > WORD_BITS)
        begin
            emit_byte(held_byte | (cw >> held_bits), 1'b0);
            held_byte = cw << (WORD_BITS - held_bits);
            held_bits = held_bits + n - WORD_BITS;
        end
        else
        begin
            held_byte = held_byte | (cw >> held_bits);
            held_bits = held_bits + n;
        end
        // end of stream: flush whatever is held, then clear
        if (it.sym == end_sym_cfg)
        begin
            emit_byte(held_byte, 1'b1);
            held_byte    = '0;
            held_bits    = 0;
            stream_count = '0;
        end
    endtask

    task automatic queue_write(input int sym, input int code, input int len);
        packer_item_t it;
        it.op   = OP_WRITE;
        it.sym  = SYM_BITS'(sym);
        it.code = WORD_BITS'(code);
        it.len  = LEN_BITS'(len);
        pending_items.push_back(it);
        if (!gen_written[sym])
        begin
            gen_written[sym] = 1'b1;
            known_syms.push_back(it.sym);
        end
    endtask

    // code_word and code_length are don't-care on encode, so scramble them
    task automatic queue_encode(input int sym);
        packer_item_t it;
        it.op   = OP_ENCODE;
        it.sym  = SYM_BITS'(sym);
        it.code = WORD_BITS'($urandom_range(0, 255));
        it.len  = LEN_BITS'($urandom_range(0, 15));
        pending_items.push_back(it);
    endtask

    // mostly 1..8, now and then empty or over-long
    function automatic int rand_len();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return $urandom_range(9, 15);
        return $urandom_range(1, 8);
    endfunction

    // hold the sender until the packer has delivered everything
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write the end symbol register and read it back
    task automatic set_end_symbol(input logic [SYM_BITS-1:0] value);
        logic [31:0] readback;
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {CFG_IDX_END_SYMBOL, 2'b00};
        pwdata  = {24'b0, value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        end_sym_cfg = value;
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== {24'b0, value})
        begin
            $display("%0t: end_symbol readback expected %h got %h", $time, value, readback);
            mismatches++;
        end
    endtask

    // random streams: a table preload, then mostly encodes with end symbols
    // sprinkled in and the odd table rewrite as noise
    task automatic queue_streams(input int count);
        int pick;
        queue_write(end_sym_cfg, $urandom_range(0, 255), rand_len());
        repeat (8) queue_write($urandom_range(0, 255), $urandom_range(0, 255), rand_len());
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                queue_write($urandom_range(0, 255), $urandom_range(0, 255), rand_len());
            else if (pick < 16)
                queue_encode(end_sym_cfg);
            else
                queue_encode(known_syms[$urandom_range(0, known_syms.size() - 1)]);
        end
    endtask

    // input driver: hold a beat until taken, otherwise idle or offer the next item
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !in_fire))
        begin
            if (tx_gap > 0)
            begin
                in_valid <= 1'b0;
                tx_gap--;
            end
            else if (pending_items.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (idle_bursts && $urandom_range(0, 9) == 0)
            begin
                in_valid <= 1'b0;
                tx_gap = $urandom_range(1, 14) - 1;
            end
            else
            begin
                in_valid    <= 1'b1;
                operation   <= pending_items[0].op;
                symbol      <= pending_items[0].sym;
                code_word   <= pending_items[0].code;
                code_length <= pending_items[0].len;
                void'(pending_items.pop_front());
            end
        end
    end

    // output side: one long hold-off on request, else random stall bursts
    always @(negedge clk)
    begin
        if (rx_hold_req && !rx_hold_done)
        begin
            rx_hold_left = LONG_HOLD;
            rx_hold_done = 1'b1;
        end
        if (rx_hold_left > 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end
        else if (rx_gap > 0)
        begin
            out_ready <= 1'b0;
            rx_gap--;
        end
        else if (idle_bursts && $urandom_range(0, 9) == 0)
        begin
            out_ready <= 1'b0;
            rx_gap = $urandom_range(1, 14) - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // monitor: predict on input beats, check output beats, watch for a hang
    always @(posedge clk)
    begin
        result_t exp_beat;
        in_fire = rst_n && in_valid && in_ready;
        if (in_fire)
            pack_item('{op: operation, sym: symbol, code: code_word, len: code_length});
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, got byte %h last %b count %0d",
                         $time, out_byte, last, byte_count);
                mismatches++;
            end
            else
            begin
                exp_beat = expected_bytes.pop_front();
                if (out_byte !== exp_beat.out_byte)
                begin
                    $display("%0t: out_byte expected %h got %h",
                             $time, exp_beat.out_byte, out_byte);
                    mismatches++;
                end
                if (last !== exp_beat.last)
                begin
                    $display("%0t: last expected %b got %b", $time, exp_beat.last, last);
                    mismatches++;
                end
                if (byte_count !== exp_beat.byte_count)
                begin
                    $display("%0t: byte_count expected %0d got %0d",
                             $time, exp_beat.byte_count, byte_count);
                    mismatches++;
                end
            end
        end
        if (!rst_n || in_fire || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [SYM_BITS-1:0] phase_end [NUM_PHASES];
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: end symbol 0 from reset
        queue_write(0, 8'h5A, 4);
        queue_write(255, 8'hFF, 8);
        queue_write(1, 8'hFF, 0);       // zero length, stray bits
        queue_write(2, 8'hC3, 15);      // over-long length acts as eight
        queue_write(3, 8'hBF, 3);       // stray bits below the length
        queue_write(128, 8'h00, 8);
        queue_encode(0);                // end symbol on an empty stream
        queue_encode(255);              // exactly full byte is held
        queue_encode(1);
        queue_encode(2);                // overflow pushes the full byte out
        queue_encode(3);
        queue_encode(128);
        queue_encode(0);
        queue_encode(0);
        queue_write(0, 8'hFF, 0);       // end symbol with no bits
        queue_encode(0);                // flush of an empty partial byte
        queue_encode(255);
        queue_encode(0);                // flush of a full held byte
        queue_encode(255);
        queue_encode(255);
        queue_write(0, 8'hAB, 8);
        queue_encode(0);                // end symbol emits two beats
        wait_drained();

        phase_end[0] = 8'hFF;
        phase_end[1] = SYM_BITS'($urandom_range(1, 254));
        phase_end[2] = 8'h00;
        for (int p = 3; p < NUM_PHASES; p++)
            phase_end[p] = SYM_BITS'($urandom_range(0, 255));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_end_symbol(phase_end[p]);
            if (p == 1)
                rx_hold_req = 1'b1;
            if (p == NUM_PHASES - 1)
                idle_bursts = 1'b0;
            queue_streams(PHASE_ITEMS);
            wait_drained();
        end

        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/hcbp_pkg.sv
hdl/hcbp_ram.sv
hdl/hcbp_out_fifo.sv
hdl/huffman_code_bit_packer.sv
bench/tb.sv
